// File: src/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
  localparam int MaxBlocks = 128;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);

  localparam logic [31:0] RegionStartReset = 32'h0001_0000;
  localparam logic [31:0] SearchLimitReset = 32'h0001_0500;
  localparam logic [31:0] MaxSizeReset = 32'd1280;

  typedef enum logic [1:0] {
    CFG_REGION_START = 2'd0,
    CFG_SEARCH_LIMIT = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_FULL = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE = 1'b1
  } command_t;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAND_RD,
    S_CAND_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [31:0]     wstart;
    logic [31:0]     wlength;
    logic [IdxW-1:0] raddr;
  } mem_ctrl_t;
endpackage

// File: src/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// channel  dir  handshake       payload
// in       in   in_valid/stall  ffba_pkg::request_t
// out      out  valid/stall     ffba_pkg::result_t
// cfg      in   valid/ready     cfg_index, cfg_data
// one request at a time; allocate scans every held block for each candidate
// (region start, then each block end); free searches and then compacts
// the table ram (one read, one write port) sets the pace of these walks
// the result is offered in S_DONE and held while out_stall is high
// sync reset clears state and count and loads the cfg defaults; table contents are undefined
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffba_pkg::request_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffba_pkg::result_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ffba_pkg::*;

  logic [31:0] region_start;
  logic [31:0] search_limit;
  logic [31:0] max_size;
  mem_ctrl_t   mem;
  logic [31:0] rstart;
  logic [31:0] rlength;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= RegionStartReset;
      search_limit <= SearchLimitReset;
      max_size <= MaxSizeReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REGION_START: region_start <= cfg_data;
        CFG_SEARCH_LIMIT: search_limit <= cfg_data;
        CFG_MAX_SIZE: max_size <= cfg_data;
        default: ;
      endcase
    end
  end

  ffba_table u_table (.clk(clk), .ctrl(mem), .rstart(rstart), .rlength(rlength));

  ffba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .region_start(region_start), .search_limit(search_limit), .max_size(max_size),
    .mem(mem), .rstart(rstart), .rlength(rlength)
  );
endmodule

// File: src/ffba_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: start and length per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module ffba_table (
  input  logic                clk,
  input  ffba_pkg::mem_ctrl_t ctrl,
  output logic [31:0]         rstart,
  output logic [31:0]         rlength
);
  import ffba_pkg::*;

  logic [63:0] mem [MaxBlocks];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= {ctrl.wstart, ctrl.wlength};
    end
    {rstart, rlength} <= mem[ctrl.raddr];
  end
endmodule

// File: src/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: candidate walk for allocate, search and compaction for free.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::request_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::result_t   out_data,
  input  logic [31:0]         region_start,
  input  logic [31:0]         search_limit,
  input  logic [31:0]         max_size,
  output ffba_pkg::mem_ctrl_t mem,
  input  logic [31:0]         rstart,
  input  logic [31:0]         rlength
);
  import ffba_pkg::*;

  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] ci;
  logic [CntW-1:0] si;
  logic [32:0] cand;
  logic [32:0] best;
  logic found;
  logic conflict;
  logic [31:0] size;
  logic [31:0] addr;
  logic [32:0] blk_end;
  logic [32:0] span_end;
  logic cand_ok_win;
  logic take;
  logic [32:0] pick;
  logic last_si;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign blk_end = {1'b0, rstart} + {1'b0, rlength};
  assign span_end = cand + {1'b0, size};
  assign cand_ok_win = (cand >= {1'b0, region_start}) && (cand < {1'b0, search_limit})
                       && (span_end <= 33'h1_0000_0000);
  assign take = !conflict && cand_ok_win && (!found || cand < best);
  assign pick = take ? cand : best;
  assign last_si = (si + 1'b1 == count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_FREE) begin
            state_next = (count == '0) ? S_DONE : S_FIND_RD;
          end else if (in_data.request_size == '0 || in_data.request_size > max_size
                       || count >= CntW'(MaxBlocks)) begin
            state_next = S_DONE;
          end else begin
            state_next = (count == '0) ? S_CAND_CHK : S_SCAN_RD;
          end
        end
      end
      S_CAND_RD: state_next = S_SCAN_RD;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = last_si ? S_CAND_CHK : S_SCAN_RD;
      S_CAND_CHK: begin
        if (ci == count) state_next = S_DONE;
        else state_next = S_CAND_RD;
      end
      S_FIND_RD: state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (rstart == addr) state_next = last_si ? S_DONE : S_SHIFT_RD;
        else state_next = last_si ? S_DONE : S_FIND_RD;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = last_si ? S_DONE : S_SHIFT_RD;
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem = '0;
    case (state)
      S_CAND_RD: mem.raddr = ci[IdxW-1:0];
      S_SCAN_RD, S_FIND_RD: mem.raddr = si[IdxW-1:0];
      S_SHIFT_RD: mem.raddr = IdxW'(si + 1'b1);
      S_SHIFT_WR: begin
        mem.we = 1'b1;
        mem.waddr = si[IdxW-1:0];
        mem.wstart = rstart;
        mem.wlength = rlength;
      end
      S_CAND_CHK: begin
        if (ci == count && (found || take)) begin
          mem.we = 1'b1;
          mem.waddr = count[IdxW-1:0];
          mem.wstart = pick[31:0];
          mem.wlength = size;
        end
      end
      default: mem = '0;
    endcase
  end

  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            size <= in_data.request_size;
            addr <= in_data.block_address;
            ci <= '0;
            si <= '0;
            found <= 1'b0;
            conflict <= 1'b0;
            cand <= {1'b0, region_start};
            out_data.granted_address <= '0;
            if (in_data.command == CMD_FREE) begin
              out_data.status <= ST_NOT_FOUND;
            end else if (in_data.request_size == '0 || in_data.request_size > max_size) begin
              out_data.status <= ST_BAD_SIZE;
            end else if (count >= CntW'(MaxBlocks)) begin
              out_data.status <= ST_FULL;
            end else begin
              out_data.status <= ST_NO_SPACE;
            end
          end
        end
        S_SCAN_CHK: begin
          if (cand < blk_end && {1'b0, rstart} < span_end) conflict <= 1'b1;
          si <= si + 1'b1;
        end
        S_CAND_CHK: begin
          if (take) begin
            best <= cand;
            found <= 1'b1;
          end
          if (ci == count && (found || take)) begin
            count <= count + 1'b1;
            out_data.status <= ST_OK;
            out_data.granted_address <= pick[31:0];
          end
          conflict <= 1'b0;
          si <= '0;
        end
        S_SCAN_RD: begin
          if (si == '0 && ci != '0) cand <= blk_end;
        end
        S_CAND_RD: ci <= ci + 1'b1;
        default: ;
      endcase
      if (state == S_FIND_CHK) begin
        if (rstart == addr) begin
          out_data.status <= ST_OK;
          count <= count - 1'b1;
        end else begin
          si <= si + 1'b1;
        end
      end
      if (state == S_SHIFT_WR) si <= si + 1'b1;
    end
  end
endmodule

// File: src/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the allocator core.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ffba_pkg::result_t out_data
);
  import ffba_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_NOT_FOUND) else $error("bad status code");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.granted_address == '0)
    else $error("address on failure");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
endmodule

bind first_fit_block_allocator_core ffba_checker u_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
